FILE: rtl/core/u8d_pkg.sv
// ============================================================================
// u8d_pkg: shared types and constants of the UTF-8 decoder
// Byte classes, the queued result entry and the code point constants.
// ============================================================================
package u8d_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned CNT_W       = 3;   // results per item, 0..4
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_CP_2B  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_3B  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_4B  = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

  typedef enum logic [1:0] {
    CLS_ASCII,
    CLS_LEAD,
    CLS_INVALID
  } u8d_class_e;

  // One queued entry: cnt results, the first cnt-1 are replacements,
  // the last carries cp and rep.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
    logic             rep;
  } u8d_entry_t;

endpackage

FILE: rtl/core/u8d_front.sv
// ============================================================================
// u8d_front: byte classifier and sequence tracker
// Accepts bytes, keeps the pending sequence and builds one entry per byte.
// ============================================================================
module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_acc_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output u8d_entry_t entry_o,
  output logic       push_o
);

  logic            seq_q, seq_d;
  logic [1:0]      need_q, need_d;
  logic [1:0]      taken_q, taken_d;
  logic [CP_W-1:0] bits_q, bits_d;

  u8d_class_e      cls;
  logic [1:0]      lead_need;
  logic [CP_W-1:0] lead_bits;
  logic            is_cont;
  logic [CNT_W-1:0] taken_inc;
  logic [CNT_W-1:0] pre;
  logic [CP_W-1:0] g_shift;
  logic            bad;
  logic            fresh;

  always_comb begin
    lead_need = 2'd0;
    lead_bits = '0;
    if (in_byte_i[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (in_byte_i[7:5] == 3'b110) begin
      cls       = CLS_LEAD;
      lead_need = 2'd1;
      lead_bits = {16'b0, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'b1110) begin
      cls       = CLS_LEAD;
      lead_need = 2'd2;
      lead_bits = {17'b0, in_byte_i[3:0]};
    end else if (in_byte_i[7:3] == 5'b11110) begin
      cls       = CLS_LEAD;
      lead_need = 2'd3;
      lead_bits = {18'b0, in_byte_i[2:0]};
    end else begin
      cls = CLS_INVALID;
    end
  end

  assign is_cont   = (in_byte_i[7:6] == 2'b10);
  assign taken_inc = {1'b0, taken_q} + 3'd1;
  assign g_shift   = {bits_q[CP_W-7:0], in_byte_i[5:0]};
  assign bad       = ((need_q == 2'd1) && (g_shift < MIN_CP_2B)) ||
                     ((need_q == 2'd2) && (g_shift < MIN_CP_3B)) ||
                     ((need_q == 2'd3) && (g_shift < MIN_CP_4B)) ||
                     ((g_shift >= SURR_LO) && (g_shift <= SURR_HI));

  always_comb begin
    seq_d         = seq_q;
    need_d        = need_q;
    taken_d       = taken_q;
    bits_d        = bits_q;
    entry_o.cnt   = '0;
    entry_o.cp    = REPL_CP;
    entry_o.rep   = 1'b1;
    fresh         = 1'b1;
    pre           = '0;

    if (seq_q) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (taken_inc >= {1'b0, need_q}) begin
          // sequence complete: emit it or replace every byte of it
          if (bad) begin
            entry_o.cnt = {1'b0, need_q} + 3'd1;
          end else begin
            entry_o.cnt = 3'd1;
            entry_o.cp  = g_shift;
            entry_o.rep = 1'b0;
          end
          seq_d = 1'b0;
        end else if (end_of_text_i) begin
          entry_o.cnt = taken_inc + 3'd1;
          seq_d       = 1'b0;
        end else begin
          bits_d  = g_shift;
          taken_d = taken_inc[1:0];
        end
      end else begin
        // broken sequence: replace lead and taken bytes, decode byte anew
        pre   = {1'b0, taken_q} + 3'd1;
        seq_d = 1'b0;
      end
    end

    if (fresh) begin
      case (cls)
        CLS_ASCII: begin
          entry_o.cnt = pre + 3'd1;
          entry_o.cp  = {13'b0, in_byte_i};
          entry_o.rep = 1'b0;
        end
        CLS_LEAD: begin
          if (end_of_text_i) begin
            entry_o.cnt = pre + 3'd1;
          end else begin
            entry_o.cnt = pre;
            seq_d       = 1'b1;
            need_d      = lead_need;
            taken_d     = 2'd0;
            bits_d      = lead_bits;
          end
        end
        default: begin
          entry_o.cnt = pre + 3'd1;
        end
      endcase
    end

    if (end_of_text_i) begin
      seq_d   = 1'b0;
      need_d  = 2'd0;
      taken_d = 2'd0;
      bits_d  = '0;
    end
  end

  assign push_o = in_acc_i && (entry_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 1'b0;
      need_q  <= 2'd0;
      taken_q <= 2'd0;
      bits_q  <= '0;
    end else if (in_acc_i) begin
      seq_q   <= seq_d;
      need_q  <= need_d;
      taken_q <= taken_d;
      bits_q  <= bits_d;
    end
  end

`ifndef SYNTHESIS
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_i && end_of_text_i |=> !seq_q && (taken_q == 2'd0))
    else $error("sequence still pending after end of text");
  a_taken_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q |-> (taken_q < need_q))
    else $error("pending sequence holds too many continuation bytes");
`endif

endmodule

FILE: rtl/core/u8d_queue.sv
// ============================================================================
// u8d_queue: short entry queue between front and back
// Register-based FIFO with full and empty flags.
// ============================================================================
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  u8d_entry_t wdata_i,
  input  logic       pop_i,
  output u8d_entry_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8d_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == CntW'(Depth));
  assign empty_o = (fill_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/u8d_back.sv
// ============================================================================
// u8d_back: result sequencer
// Pops entries and hands out their results one item per cycle while out_stall_i is low.
// ============================================================================
module u8d_back import u8d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8d_entry_t      head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CP_W-1:0] code_point_o,
  output logic            replaced_o,
  output logic            last_of_run_o
);

  logic             valid_q;
  logic [CNT_W-1:0] left_q;
  logic [CP_W-1:0]  cp_q;
  logic             rep_q;
  logic             out_acc;
  logic             last;

  assign last    = (left_q == 3'd1);
  assign out_acc = valid_q && !out_stall_i;
  assign pop_o   = !empty_i && (!valid_q || (out_acc && last));

  // leading results of an entry are replacements, the last one carries cp
  assign out_valid_o   = valid_q;
  assign code_point_o  = last ? cp_q : REPL_CP;
  assign replaced_o    = last ? rep_q : 1'b1;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cp_q  <= head_i.cp;
      rep_q <= head_i.rep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      left_q  <= head_i.cnt;
    end else if (out_acc) begin
      valid_q <= !last;
      left_q  <= left_q - 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (left_q != '0) && (left_q <= 3'd4))
    else $error("result count out of range");
`endif

endmodule

FILE: rtl/core/utf8_decoder_with_replacement.sv
// A result passes through the entry queue, then the sequencer's output register.
// Throughput: one byte per cycle while the queue has room and each byte yields
// at most one result; a byte yielding more (up to 4) holds the output side until
// its last result is taken; the classifier-to-sequencer queue absorbs the burst.
// Reset: rst_ni clears the pending sequence, the queue and the output valid.
// ============================================================================
// utf8_decoder_with_replacement: streaming UTF-8 decoder
// Decodes bytes to code points, replacing bad input with U+FFFD.
// ============================================================================
module utf8_decoder_with_replacement import u8d_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input bytes
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_text_i,
  // decoded code points
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CP_W-1:0] code_point_o,
  output logic            replaced_o,
  output logic            last_of_run_o
);

  u8d_entry_t entry;
  u8d_entry_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic       in_acc;

  // Hold the input while the queue has no room; a byte that yields no
  // result is still consumed here, it just pushes nothing.
  assign in_stall_o = q_full;
  assign in_acc     = in_valid_i && !q_full;

  // Front: classify each byte, track the pending sequence, build an entry.
  u8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_acc_i      (in_acc),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .entry_o       (entry),
    .push_o        (push)
  );

  // Queue: decouple the byte side from the result side.
  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry),
    .pop_i   (pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: expand each entry into its run of result items.
  u8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef SYNTHESIS
  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> in_acc)
    else $error("entry pushed without an accepted byte");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the streaming UTF-8 decoder
// Feeds directed and random byte streams through the valid/stall handshake,
// predicts every decoded code point and replacement, and checks each result
// in order against that prediction.
// ============================================================================
module tb;
  import u8d_pkg::*;

  // Stop a hung run well past the slowest legal one.
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DIR_ROWS    = 24;
  localparam int unsigned PHASE_ITEMS = 96;
  // Keep the log bounded when the block is badly broken.
  localparam int unsigned REPORT_CAP  = 200;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            rep;
    logic            last;
  } cp_result_t;

  // One directed row: the byte, its end mark, and an optional literal result
  // for rows whose single result is obvious without the predictor.
  typedef struct packed {
    logic [7:0]      b;
    logic            eot;
    logic            lit;
    logic [CP_W-1:0] cp;
    logic            rep;
  } stim_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      in_byte_i;
  logic            end_of_text_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [CP_W-1:0] code_point_o;
  logic            replaced_o;
  logic            last_of_run_o;

  // Literal expectation that travels with the item on the input side.
  logic            lit_on;
  logic [CP_W-1:0] lit_cp;
  logic            lit_rep;

  // Predicted decoder state.
  logic            dec_active;
  logic [1:0]      dec_need;
  logic [1:0]      dec_taken;
  logic [CP_W-1:0] dec_bits;

  cp_result_t      step_q[$];     // results of the byte being decoded
  cp_result_t      cp_due_q[$];   // code points still owed by the block
  int unsigned     errors;
  int unsigned     cycles;
  int unsigned     send_pct;
  int unsigned     recv_pct;

  utf8_decoder_with_replacement dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Decoder prediction
  // --------------------------------------------------------------------------

  // Append one result; a single byte never yields more than four.
  task automatic put_cp(input logic [CP_W-1:0] cp, input logic rep);
    if (step_q.size() < 4) step_q.push_back('{cp, rep, 1'b0});
  endtask

  task automatic put_repl(input int cnt);
    for (int i = 0; i < cnt; i++) put_cp(REPL_CP, 1'b1);
  endtask

  task automatic clear_dec();
    dec_active = 1'b0;
    dec_need   = 2'd0;
    dec_taken  = 2'd0;
    dec_bits   = '0;
  endtask

  // Decode one accepted byte into step_q and advance the predicted state.
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic            fresh;
    logic            lead;
    logic            bad;
    logic [1:0]      need;
    logic [CP_W-1:0] bits;
    cp_result_t      tail;
    step_q.delete();
    fresh = 1'b1;
    lead  = 1'b1;
    need  = 2'd0;
    bits  = '0;

    if (dec_active) begin
      if (b[7:6] == 2'b10) begin
        // Continuation: gather six more payload bits.
        fresh     = 1'b0;
        dec_bits  = {dec_bits[CP_W-7:0], b[5:0]};
        dec_taken = dec_taken + 2'd1;
        if (dec_taken >= dec_need) begin
          // Sequence complete: reject overlong forms and surrogates.
          bad = (dec_need == 2'd1 && dec_bits < MIN_CP_2B) ||
                (dec_need == 2'd2 && dec_bits < MIN_CP_3B) ||
                (dec_need == 2'd3 && dec_bits < MIN_CP_4B) ||
                (dec_bits >= SURR_LO && dec_bits <= SURR_HI);
          if (bad) put_repl(1 + int'(dec_need));
          else put_cp(dec_bits, 1'b0);
          clear_dec();
        end else if (eot) begin
          // Text ends mid-sequence: replace the lead and what was taken.
          put_repl(1 + int'(dec_taken));
          clear_dec();
        end
      end else begin
        // Interrupted sequence: replace it, then decode this byte afresh.
        put_repl(1 + int'(dec_taken));
        clear_dec();
      end
    end

    if (fresh) begin
      if (b[7] == 1'b0) begin
        put_cp({{(CP_W-8){1'b0}}, b}, 1'b0);
        lead = 1'b0;
      end else if (b[7:5] == 3'b110) begin
        need = 2'd1;
        bits = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need = 2'd2;
        bits = {{(CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need = 2'd3;
        bits = {{(CP_W-3){1'b0}}, b[2:0]};
      end else begin
        // Stray continuation or a byte that can never lead.
        put_repl(1);
        lead = 1'b0;
      end
      if (lead) begin
        if (eot) begin
          put_repl(1);
        end else begin
          dec_active = 1'b1;
          dec_need   = need;
          dec_taken  = 2'd0;
          dec_bits   = bits;
        end
      end
    end

    if (eot) clear_dec();
    if (step_q.size() > 0) begin
      tail = step_q[step_q.size()-1];
      tail.last = 1'b1;
      step_q[step_q.size()-1] = tail;
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input acceptance, check on output acceptance.
  // Both sides are handled in one process so the same-edge order is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cp_result_t got;
    cp_result_t want;
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d code points outstanding", $time, cp_due_q.size());
      $display("tb: failure");
      $finish;
    end

    if (in_valid_i && !in_stall_o) begin
      decode_byte(in_byte_i, end_of_text_i);
      // Literal rows carry exactly one result; the predictor still advances.
      if (lit_on) cp_due_q.push_back('{lit_cp, lit_rep, 1'b1});
      else foreach (step_q[i]) cp_due_q.push_back(step_q[i]);
    end

    if (out_valid_o && !out_stall_i) begin
      got = '{code_point_o, replaced_o, last_of_run_o};
      if (cp_due_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < REPORT_CAP)
          $display("%0t: unexpected result: expected none, got cp=%h rep=%b last=%b",
                   $time, got.cp, got.rep, got.last);
      end else begin
        want = cp_due_q.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < REPORT_CAP)
            $display("%0t: mismatch: expected cp=%h rep=%b last=%b, got cp=%h rep=%b last=%b",
                     $time, want.cp, want.rep, want.last, got.cp, got.rep, got.last);
        end
      end
    end
  end

  // Receiver: stall at the rate of the current phase.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  // Offer one item, idling first at the sender's rate, and hold it until taken.
  task automatic send_byte(input logic [7:0] b, input logic eot, input logic lit,
                           input logic [CP_W-1:0] cp, input logic rep);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    lit_on        <= lit;
    lit_cp        <= cp;
    lit_rep       <= rep;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t       dir_tab [DIR_ROWS];
    logic [7:0]      seq_q[$];
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] min_cp;
    logic            eot_at_end;
    int unsigned     sent;
    int unsigned     kind;
    int unsigned     len;
    int unsigned     cut;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = 8'h00;
    end_of_text_i = 1'b0;
    lit_on        = 1'b0;
    lit_cp        = '0;
    lit_rep       = 1'b0;
    errors        = 0;
    cycles        = 0;
    sent          = 0;
    send_pct      = 18;
    recv_pct      = 52;
    clear_dec();

    dir_tab = '{
      // Single-result rows right after reset: ASCII extremes, a stray continuation, a byte that never leads.
      '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
      '{8'h80, 1'b0, 1'b1, REPL_CP,    1'b1},
      '{8'hFF, 1'b1, 1'b1, REPL_CP,    1'b1},
      // Valid two-byte form.
      '{8'hC2, 1'b0, 1'b0, '0, 1'b0},
      '{8'hA9, 1'b0, 1'b0, '0, 1'b0},
      // Overlong two-byte form.
      '{8'hC0, 1'b0, 1'b0, '0, 1'b0},
      '{8'h80, 1'b0, 1'b0, '0, 1'b0},
      // Surrogate.
      '{8'hED, 1'b0, 1'b0, '0, 1'b0},
      '{8'hA0, 1'b0, 1'b0, '0, 1'b0},
      '{8'h80, 1'b0, 1'b0, '0, 1'b0},
      // Large lead, largest code point.
      '{8'hF7, 1'b0, 1'b0, '0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, '0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, '0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, '0, 1'b0},
      // Sequence broken by ASCII.
      '{8'hE2, 1'b0, 1'b0, '0, 1'b0},
      '{8'h82, 1'b0, 1'b0, '0, 1'b0},
      '{8'h41, 1'b0, 1'b0, '0, 1'b0},
      // Broken after two continuations by a lead that ends the text.
      '{8'hF4, 1'b0, 1'b0, '0, 1'b0},
      '{8'h8F, 1'b0, 1'b0, '0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, '0, 1'b0},
      '{8'hC3, 1'b1, 1'b0, '0, 1'b0},
      // Text cut off inside a sequence.
      '{8'hE2, 1'b0, 1'b0, '0, 1'b0},
      '{8'h82, 1'b1, 1'b0, '0, 1'b0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].eot, dir_tab[i].lit, dir_tab[i].cp, dir_tab[i].rep);
      sent++;
    end

    // Random part in three idling phases: sender light/receiver heavy,
    // then swapped, then no idling at all.
    for (int ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 18 : (ph == 1) ? 52 : 0;
      recv_pct = (ph == 0) ? 52 : (ph == 1) ? 18 : 0;
      while (sent < DIR_ROWS + PHASE_ITEMS * (ph + 1)) begin
        kind = $urandom_range(99);
        len  = (kind < 12) ? 1 : $urandom_range(4, 2);
        case (len)
          1:       cp = CP_W'($urandom_range(8'h7F));
          2:       cp = CP_W'($urandom_range(12'h7FF, 8'h80));
          3:       cp = CP_W'($urandom_range(16'hFFFF, 12'h800));
          default: cp = CP_W'($urandom_range(21'h1FFFFF, 17'h10000));
        endcase
        min_cp = (len == 2) ? MIN_CP_2B : (len == 3) ? MIN_CP_3B : MIN_CP_4B;
        // Force an overlong form, or a surrogate in a three-byte form.
        if (kind >= 60 && kind < 72 && len > 1) cp = CP_W'($urandom_range(min_cp - 1));
        if (kind >= 72 && kind < 78 && len == 3) cp = CP_W'($urandom_range(SURR_HI, SURR_LO));

        seq_q.delete();
        case (len)
          1: seq_q.push_back({1'b0, cp[6:0]});
          2: begin
            seq_q.push_back({3'b110, cp[10:6]});
            seq_q.push_back({2'b10, cp[5:0]});
          end
          3: begin
            seq_q.push_back({4'b1110, cp[15:12]});
            seq_q.push_back({2'b10, cp[11:6]});
            seq_q.push_back({2'b10, cp[5:0]});
          end
          default: begin
            seq_q.push_back({5'b11110, cp[20:18]});
            seq_q.push_back({2'b10, cp[17:12]});
            seq_q.push_back({2'b10, cp[11:6]});
            seq_q.push_back({2'b10, cp[5:0]});
          end
        endcase

        // Truncate so the next sequence breaks this one.
        if (kind >= 78 && kind < 90 && len > 1) begin
          cut = $urandom_range(len - 1, 1);
          while (seq_q.size() > cut) void'(seq_q.pop_back());
        end
        // Noise: any byte, sometimes followed by a stray continuation.
        if (kind >= 90) begin
          seq_q.delete();
          seq_q.push_back(8'($urandom_range(255)));
          if ($urandom_range(1)) seq_q.push_back({2'b10, 6'($urandom_range(63))});
        end

        eot_at_end = ($urandom_range(99) < 10);
        foreach (seq_q[i]) begin
          send_byte(seq_q[i],
                    ((i == seq_q.size() - 1) && eot_at_end) || ($urandom_range(99) < 2),
                    1'b0, '0, 1'b0);
          sent++;
        end
      end
    end

    // Drop valid, drain what is owed, then keep watching for strays.
    in_valid_i <= 1'b0;
    while (cp_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
